// File: rtl/mdsc_pkg.sv
package mdsc_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned SeqW  = 20;

  localparam logic [ByteW-1:0] ChNewline = 8'h0A;
  localparam logic [ByteW-1:0] ChAt      = 8'h40;
  localparam logic [ByteW-1:0] ChPipe    = 8'h7C;
  localparam logic [ByteW-1:0] ChZero    = 8'h30;
  localparam logic [ByteW-1:0] ChNine    = 8'h39;

  localparam logic [SeqW-1:0] SeqMax        = 20'd1048575;
  localparam logic [SeqW-1:0] SeqWrap       = 20'd999999;
  localparam logic [SeqW-1:0] MaxFrameReset = 20'd262144;

  localparam logic [2:0] VerdictOk         = 3'd0;
  localparam logic [2:0] VerdictNoNumber   = 3'd1;
  localparam logic [2:0] VerdictOutOfOrder = 3'd2;
  localparam logic [2:0] VerdictDuplicate  = 3'd3;
  localparam logic [2:0] VerdictGarbled    = 3'd4;

  localparam logic KindContent = 1'b0;
  localparam logic KindEnd     = 1'b1;

  typedef struct packed {
    logic             item_kind;
    logic [ByteW-1:0] content_byte;
    logic [2:0]       verdict;
    logic             was_truncated;
    logic [SeqW-1:0]  seq_number;
  } result_t;

endpackage

// File: rtl/mdsc_parse.sv
module mdsc_parse import mdsc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            take_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic [SeqW-1:0] max_frame_bytes_i,
  output logic            res_valid_o,
  output result_t         res_o
);

  localparam logic [1:0] HdrNone = 2'd0;
  localparam logic [1:0] HdrOneAt = 2'd1;
  localparam logic [1:0] HdrGood = 2'd2;
  localparam logic [1:0] HdrBad = 2'd3;

  localparam logic [1:0] PhSearch = 2'd0;
  localparam logic [1:0] PhDigits = 2'd1;
  localparam logic [1:0] PhEnded = 2'd2;
  localparam logic [1:0] PhNone = 2'd3;

  logic [ByteW-1:0] hold_q [3];
  logic [1:0]       hold_count_q, hold_count_d;
  logic [1:0]       prog_q, prog_d;
  logic [SeqW-1:0]  emitted_q, emitted_d;
  logic [1:0]       header_q, header_d;
  logic [1:0]       phase_q, phase_d;
  logic [SeqW-1:0]  value_q, value_d;
  logic [SeqW-1:0]  tracker_q, tracker_d;
  logic             skip_q, skip_d;

  logic             hold_wr, hold_shift;
  logic [ByteW-1:0] marker_byte;
  logic             marker_match, marker_end;
  logic [1:0]       np;

  logic [2:0]       close_verdict;
  logic [SeqW-1:0]  close_seq, close_tracker;

  logic [ByteW-1:0] oldest;
  logic             is_digit;
  logic [3:0]       digit;
  logic [SeqW+3:0]  value_ext;
  logic [1:0]       header_c, phase_c;
  logic [SeqW-1:0]  value_c;

  always_comb begin
    case (prog_q)
      2'd1, 2'd2: marker_byte = ChAt;
      default:    marker_byte = ChNewline;
    endcase
    marker_match = (byte_i == marker_byte);
    marker_end   = marker_match && (prog_q == 2'd3);
    np = marker_match ? prog_q + 2'd1 : {1'b0, byte_i == ChNewline};
  end

  // Sequence verdict for the frame being closed.
  always_comb begin
    close_tracker = tracker_q;
    close_seq     = '0;
    if (header_q != HdrGood) begin
      close_verdict = VerdictGarbled;
    end else if (phase_q == PhDigits || phase_q == PhEnded) begin
      close_seq = value_q;
      if (tracker_q == '0 || ({1'b0, tracker_q} + 21'd1) == {1'b0, value_q}) begin
        close_verdict = VerdictOk;
        close_tracker = value_q;
      end else if (value_q == tracker_q) begin
        close_verdict = VerdictDuplicate;
      end else begin
        close_verdict = VerdictOutOfOrder;
        close_tracker = value_q;
      end
      if (close_tracker == SeqWrap) begin
        close_tracker = '0;
      end
    end else begin
      close_verdict = VerdictNoNumber;
    end
  end

  // Header and number tracking for the byte leaving the hold.
  always_comb begin
    oldest    = hold_q[0];
    is_digit  = (oldest >= ChZero) && (oldest <= ChNine);
    digit     = oldest[3:0];
    value_ext = {1'b0, value_q, 3'b000} + {3'b000, value_q, 1'b0} + {20'd0, digit};
    header_c  = header_q;
    phase_c   = phase_q;
    value_c   = value_q;
    if (header_q == HdrNone) begin
      header_c = (oldest == ChAt) ? HdrOneAt : HdrBad;
    end else if (header_q == HdrOneAt) begin
      header_c = (oldest == ChAt) ? HdrGood : HdrBad;
    end
    if (phase_q == PhSearch) begin
      if (is_digit) begin
        phase_c = PhDigits;
        value_c = {16'd0, digit};
      end else if (oldest == ChPipe) begin
        phase_c = PhNone;
      end
    end else if (phase_q == PhDigits) begin
      if (is_digit) begin
        value_c = (value_ext > {4'd0, SeqMax}) ? SeqMax : value_ext[SeqW-1:0];
      end else begin
        phase_c = PhEnded;
      end
    end
  end

  always_comb begin
    hold_count_d = hold_count_q;
    prog_d       = prog_q;
    emitted_d    = emitted_q;
    header_d     = header_q;
    phase_d      = phase_q;
    value_d      = value_q;
    tracker_d    = tracker_q;
    skip_d       = skip_q;
    hold_wr      = 1'b0;
    hold_shift   = 1'b0;
    res_valid_o  = 1'b0;
    res_o        = '0;
    if (take_i) begin
      if (skip_q) begin
        if (marker_end) begin
          skip_d = 1'b0;
          prog_d = 2'd0;
        end else begin
          prog_d = np;
        end
      end else if (marker_end || (hold_count_q == 2'd3 && emitted_q >= max_frame_bytes_i)) begin
        res_valid_o         = 1'b1;
        res_o.item_kind     = KindEnd;
        res_o.verdict       = close_verdict;
        res_o.was_truncated = !marker_end;
        res_o.seq_number    = close_seq;
        hold_count_d = '0;
        prog_d       = '0;
        emitted_d    = '0;
        header_d     = HdrNone;
        phase_d      = PhSearch;
        value_d      = '0;
        if (marker_end) begin
          tracker_d = close_tracker;
        end else begin
          // Truncation forgets the sequence and discards up to the next marker.
          tracker_d = '0;
          skip_d    = 1'b1;
        end
      end else if (hold_count_q != 2'd3) begin
        hold_wr      = 1'b1;
        hold_count_d = hold_count_q + 2'd1;
        prog_d       = np;
      end else begin
        hold_shift         = 1'b1;
        prog_d             = np;
        header_d           = header_c;
        phase_d            = phase_c;
        value_d            = value_c;
        emitted_d          = emitted_q + 20'd1;
        res_valid_o        = 1'b1;
        res_o.item_kind    = KindContent;
        res_o.content_byte = oldest;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hold_wr) begin
      hold_q[hold_count_q] <= byte_i;
    end else if (hold_shift) begin
      hold_q[0] <= hold_q[1];
      hold_q[1] <= hold_q[2];
      hold_q[2] <= byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_count_q <= '0;
      prog_q       <= '0;
      emitted_q    <= '0;
      header_q     <= HdrNone;
      phase_q      <= PhSearch;
      value_q      <= '0;
      tracker_q    <= '0;
      skip_q       <= 1'b0;
    end else begin
      hold_count_q <= hold_count_d;
      prog_q       <= prog_d;
      emitted_q    <= emitted_d;
      header_q     <= header_d;
      phase_q      <= phase_d;
      value_q      <= value_d;
      tracker_q    <= tracker_d;
      skip_q       <= skip_d;
    end
  end

endmodule

// File: rtl/mdsc_out_buf.sv
module mdsc_out_buf import mdsc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    res_valid_i,
  input  result_t res_i,
  input  logic    out_stall_i,
  output logic    full_o,
  output logic    out_valid_o,
  output result_t out_res_o
);

  logic    out_valid_q;
  result_t out_q;
  logic    skid_valid_q;
  result_t skid_q;
  logic    out_fire;

  assign out_fire    = out_valid_q && !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_valid_i) begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (res_valid_i) begin
      if (!out_valid_q || out_fire) begin
        out_q <= res_i;
      end else begin
        skid_q <= res_i;
      end
    end
  end

endmodule

// File: rtl/message_deframer_seq_check_core.sv
// Channel   Direction  Handshake               Payload
// input     in         in_valid_i / in_stall_o  stream_byte_i
// output    out        out_valid_o / out_stall_i item_kind_o, content_byte_o, verdict_o,
//                                               was_truncated_o, seq_number_o
// config    in         psel/penable/pwrite      paddr, pwdata, prdata, pready
//
// One input item is taken every cycle while in_stall_o is low; each gives zero or one result item,
// computed in the same cycle from the frame state registers.
// Results pass through a two-entry output stage: a registered output entry and a skid
// entry that takes a result item while the registered one is stalled.
// in_stall_o rises only when both output entries hold items.
// Reset clears all frame state and the sequence tracker, and loads the
// default frame size limit.
module message_deframer_seq_check_core import mdsc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] stream_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             item_kind_o,
  output logic [ByteW-1:0] content_byte_o,
  output logic [2:0]       verdict_o,
  output logic             was_truncated_o,
  output logic [SeqW-1:0]  seq_number_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [SeqW-1:0] max_frame_q;
  logic            take;
  logic            res_valid;
  result_t         res;
  result_t         out_res;
  logic            buf_full;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {12'd0, max_frame_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_frame_q <= MaxFrameReset;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      max_frame_q <= pwdata[SeqW-1:0];
    end
  end

  assign in_stall_o = buf_full;
  assign take       = in_valid_i && !buf_full;

  mdsc_parse u_parse (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .take_i            (take),
    .byte_i            (stream_byte_i),
    .max_frame_bytes_i (max_frame_q),
    .res_valid_o       (res_valid),
    .res_o             (res)
  );

  mdsc_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_res_o   (out_res)
  );

  assign item_kind_o     = out_res.item_kind;
  assign content_byte_o  = out_res.content_byte;
  assign verdict_o       = out_res.verdict;
  assign was_truncated_o = out_res.was_truncated;
  assign seq_number_o    = out_res.seq_number;

endmodule

// File: rtl/mdsc_checker.sv
module mdsc_checker import mdsc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic             item_kind_o,
  input logic [ByteW-1:0] content_byte_o,
  input logic [2:0]       verdict_o,
  input logic             was_truncated_o,
  input logic [SeqW-1:0]  seq_number_o
);

  // The input side stalls only while a result item is on offer.
  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result on offer");

  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |=> !in_stall_o)
    else $error("input stalled right after the output was empty");

  a_stall_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && !out_stall_i |=> !in_stall_o)
    else $error("input stall held after a result item was taken");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(item_kind_o)
      && $stable(content_byte_o) && $stable(verdict_o)
      && $stable(was_truncated_o) && $stable(seq_number_o))
    else $error("stalled result item changed");

  a_no_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && item_kind_o == KindEnd
      && (verdict_o == VerdictGarbled || verdict_o == VerdictNoNumber)
      |-> seq_number_o == '0)
    else $error("sequence number given for a frame without one");

endmodule

bind message_deframer_seq_check_core mdsc_checker u_mdsc_checker (.*);

// File: tb/message_deframer_seq_check_core_tb.sv
`timescale 1ns / 1ps

module message_deframer_seq_check_core_tb;
  import mdsc_pkg::*;

  localparam int unsigned SettleCycles = 4;
  localparam int unsigned PhaseBytes   = 300;
  localparam int unsigned NumLimits    = 6;
  localparam logic [2:0]  AddrMaxFrame = 3'd0;

  typedef enum logic [1:0] {HdrNone, HdrOneAt, HdrGood, HdrBad} hdr_e;
  typedef enum logic [1:0] {NumSearch, NumDigits, NumDone, NumAbsent} num_e;

  typedef struct packed {
    logic [ByteW-1:0] data;
    bit               pinned;
    bit               yields;
    result_t          res;
  } script_row_t;

  localparam result_t NoItem = '0;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [ByteW-1:0] stream_byte_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic             item_kind_o;
  logic [ByteW-1:0] content_byte_o;
  logic [2:0]       verdict_o;
  logic             was_truncated_o;
  logic [SeqW-1:0]  seq_number_o;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [2:0]       paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  message_deframer_seq_check_core i_dut (.*);

  // Deframer state as the block should hold it.
  logic [SeqW-1:0]  size_limit;
  logic [ByteW-1:0] held_bytes [3];
  logic [1:0]       held_n;
  logic [1:0]       mark_pos;
  logic [SeqW-1:0]  emitted;
  hdr_e             hdr_state;
  num_e             num_state;
  logic [SeqW-1:0]  num_val;
  logic [SeqW-1:0]  last_seq;
  bit               discarding;

  result_t          due_items [$];
  logic [ByteW-1:0] frame_buf [$];
  bit               sender_busy;
  bit               sink_busy;
  int unsigned      mismatches;
  int unsigned      bytes_sent;
  int unsigned      frames_sent;
  int unsigned      items_checked;
  int unsigned      ends_checked;
  int unsigned      cut_ends;
  int unsigned      limits_used;

  logic [SeqW-1:0] limit_plan [NumLimits] = '{20'd8, 20'd0, 20'd1048575, 20'd5, 20'd16, 20'd1};

  // 8'h35 is the digit 5.
  script_row_t opening_rows [25] = '{
    // A good frame carrying number 5; the first three bytes only fill the hold.
    '{ChAt,      1'b1, 1'b0, NoItem},
    '{ChAt,      1'b1, 1'b0, NoItem},
    '{8'h35,     1'b1, 1'b0, NoItem},
    '{ChNewline, 1'b1, 1'b1, '{KindContent, ChAt, VerdictOk, 1'b0, 20'd0}},
    '{ChAt,      1'b1, 1'b1, '{KindContent, ChAt, VerdictOk, 1'b0, 20'd0}},
    '{ChAt,      1'b1, 1'b1, '{KindContent, 8'h35, VerdictOk, 1'b0, 20'd0}},
    '{ChNewline, 1'b1, 1'b1, '{KindEnd, 8'h00, VerdictOk, 1'b0, 20'd5}},
    // A marker right after a marker closes an empty, garbled frame.
    '{ChNewline, 1'b1, 1'b0, NoItem},
    '{ChAt,      1'b1, 1'b0, NoItem},
    '{ChAt,      1'b1, 1'b0, NoItem},
    '{ChNewline, 1'b1, 1'b1, '{KindEnd, 8'h00, VerdictGarbled, 1'b0, 20'd0}},
    // A bar ahead of any digit leaves the frame without a number.
    '{ChAt,      1'b0, 1'b0, NoItem},
    '{ChAt,      1'b0, 1'b0, NoItem},
    '{ChPipe,    1'b0, 1'b0, NoItem},
    '{ChNewline, 1'b0, 1'b0, NoItem},
    '{ChAt,      1'b0, 1'b0, NoItem},
    '{ChAt,      1'b0, 1'b0, NoItem},
    '{ChNewline, 1'b1, 1'b1, '{KindEnd, 8'h00, VerdictNoNumber, 1'b0, 20'd0}},
    // All-ones and zero bytes up front spoil the header.
    '{8'hFF,     1'b0, 1'b0, NoItem},
    '{8'h00,     1'b0, 1'b0, NoItem},
    '{8'h35,     1'b0, 1'b0, NoItem},
    '{ChNewline, 1'b0, 1'b0, NoItem},
    '{ChAt,      1'b0, 1'b0, NoItem},
    '{ChAt,      1'b0, 1'b0, NoItem},
    '{ChNewline, 1'b1, 1'b1, '{KindEnd, 8'h00, VerdictGarbled, 1'b0, 20'd0}}
  };

  function automatic void clear_frame_state();
    foreach (held_bytes[i]) held_bytes[i] = '0;
    held_n    = '0;
    mark_pos  = '0;
    emitted   = '0;
    hdr_state = HdrNone;
    num_state = NumSearch;
    num_val   = '0;
  endfunction

  function automatic result_t close_verdict(input logic cut);
    result_t r;
    r = '0;
    r.item_kind     = KindEnd;
    r.was_truncated = cut;
    if (hdr_state != HdrGood) begin
      r.verdict = VerdictGarbled;
    end else if (num_state == NumDigits || num_state == NumDone) begin
      r.seq_number = num_val;
      if (last_seq == '0 || {1'b0, num_val} == {1'b0, last_seq} + 21'd1) begin
        r.verdict = VerdictOk;
        last_seq  = num_val;
      end else if (num_val == last_seq) begin
        r.verdict = VerdictDuplicate;
      end else begin
        r.verdict = VerdictOutOfOrder;
        last_seq  = num_val;
      end
      if (last_seq == SeqWrap) last_seq = '0;
    end else begin
      r.verdict = VerdictNoNumber;
    end
    return r;
  endfunction

  // Advances the deframer by one byte; returns 1 when the byte yields a result item.
  function automatic bit deframe_byte(input logic [ByteW-1:0] b, output result_t r);
    logic [2:0]       np;
    logic [31:0]      marker;
    logic [ByteW-1:0] oldest;
    bit               digit;
    int               v;
    r = '0;
    marker = {ChNewline, ChAt, ChAt, ChNewline};
    if (b == marker[31 - 8 * int'(mark_pos) -: 8]) np = {1'b0, mark_pos} + 3'd1;
    else np = (b == ChNewline) ? 3'd1 : 3'd0;

    if (discarding) begin
      if (np == 3'd4) begin
        discarding = 1'b0;
        mark_pos   = '0;
      end else begin
        mark_pos = np[1:0];
      end
      return 1'b0;
    end
    if (np == 3'd4) begin
      r = close_verdict(1'b0);
      clear_frame_state();
      return 1'b1;
    end
    if (held_n < 2'd3) begin
      held_bytes[held_n] = b;
      held_n++;
      mark_pos = np[1:0];
      return 1'b0;
    end
    if (emitted >= size_limit) begin
      r = close_verdict(1'b1);
      clear_frame_state();
      last_seq   = '0;
      discarding = 1'b1;
      return 1'b1;
    end

    oldest        = held_bytes[0];
    held_bytes[0] = held_bytes[1];
    held_bytes[1] = held_bytes[2];
    held_bytes[2] = b;
    mark_pos      = np[1:0];
    digit = (oldest >= ChZero) && (oldest <= ChNine);
    case (hdr_state)
      HdrNone:  hdr_state = (oldest == ChAt) ? HdrOneAt : HdrBad;
      HdrOneAt: hdr_state = (oldest == ChAt) ? HdrGood : HdrBad;
      default: ;
    endcase
    if (num_state == NumSearch) begin
      if (digit) begin
        num_state = NumDigits;
        num_val   = 20'(oldest - ChZero);
      end else if (oldest == ChPipe) begin
        num_state = NumAbsent;
      end
    end else if (num_state == NumDigits) begin
      if (digit) begin
        v = int'(num_val) * 10 + int'(oldest) - int'(ChZero);
        num_val = (v > int'(SeqMax)) ? SeqMax : 20'(v);
      end else begin
        num_state = NumDone;
      end
    end
    emitted++;
    r.item_kind    = KindContent;
    r.content_byte = oldest;
    return 1'b1;
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_buf.push_back(s[i]);
  endfunction

  function automatic void add_letters(input int unsigned n);
    repeat (n) frame_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
  endfunction

  // Mostly printable text, so digits, bars and at signs show up often.
  function automatic void add_payload();
    int unsigned len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    repeat (len) begin
      if ($urandom_range(0, 3) == 0) frame_buf.push_back(8'($urandom_range(0, 255)));
      else frame_buf.push_back(8'($urandom_range(32, 126)));
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic push_byte(input logic [ByteW-1:0] b, input bit pinned, input bit yields,
                           input result_t pinned_res);
    int unsigned gap;
    result_t     r;
    bit          made;
    gap = sender_busy ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    stream_byte_i = b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    made = deframe_byte(b, r);
    if (pinned) begin
      if (yields) due_items.push_back(pinned_res);
    end else if (made) begin
      due_items.push_back(r);
    end
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_quiet();
    in_valid_i = 1'b0;
    while (due_items.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic reg_access(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = addr;
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apply_frame_limit(input bit do_write, input logic [SeqW-1:0] v);
    logic [31:0] rd;
    if (do_write) begin
      // Upper data bits are random; only the low 20 bits belong to the register.
      reg_access(1'b1, AddrMaxFrame, {12'($urandom), v}, rd);
      size_limit = v;
      limits_used++;
    end
    reg_access(1'b0, AddrMaxFrame, '0, rd);
    check_field("max_frame_bytes", {12'd0, size_limit}, rd);
  endtask

  task automatic send_frame();
    int unsigned      pick;
    int unsigned      n;
    logic [ByteW-1:0] first;
    frame_buf.delete();
    sender_busy = ($urandom_range(0, 3) != 0);
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      // Well-formed frame; the number is steered around the tracker.
      add_text("@@");
      if ($urandom_range(0, 3) == 0) add_letters($urandom_range(1, 4));
      case ($urandom_range(0, 9))
        0, 1, 2, 3: n = (last_seq == '0) ? $urandom_range(1, 50) : int'(last_seq) + 1;
        4:       n = (last_seq == '0) ? $urandom_range(1, 50) : int'(last_seq);
        5:       n = $urandom_range(0, int'(SeqMax));
        6:       n = int'(SeqWrap) - 1;
        7:       n = int'(SeqWrap);
        8:       n = $urandom_range(1048576, 2000000000);
        default: begin
          add_text("00");
          n = int'(last_seq) + 1;
        end
      endcase
      add_text($sformatf("%0d", n));
      case ($urandom_range(0, 2))
        0: add_text("|");
        1: add_letters(1);
        default: ;
      endcase
      add_payload();
    end else if (pick < 70) begin
      add_text("@@");
      if ($urandom_range(0, 1) == 0) add_letters($urandom_range(1, 3));
      if ($urandom_range(0, 2) != 0) add_text("|");
      add_payload();
    end else if (pick < 80) begin
      do first = 8'($urandom_range(0, 255)); while (first == ChAt);
      if ($urandom_range(0, 1) == 0) add_text("@");
      frame_buf.push_back(first);
      add_text($sformatf("%0d", $urandom_range(0, 999)));
      add_payload();
    end else if (pick < 90) begin
      repeat ($urandom_range(1, 24)) frame_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      // Short frames and partial markers inside a frame.
      case ($urandom_range(0, 4))
        0: ;
        1: add_text("@");
        2: add_text("@@7\n@x");
        3: add_text("@@\n@@");
        default: add_text("@@1\n");
      endcase
      add_payload();
    end
    if (pick < 80 || pick >= 90 || $urandom_range(0, 1) == 0) add_text("\n@@\n");
    foreach (frame_buf[i]) push_byte(frame_buf[i], 1'b0, 1'b0, NoItem);
    frames_sent++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : result_sink
    int unsigned pause_n;
    result_t     got;
    result_t     want;
    out_stall_i = 1'b0;
    sink_busy   = 1'b1;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      pause_n = sink_busy ? $urandom_range(0, 14) : 0;
      if (pause_n != 0) begin
        out_stall_i = 1'b1;
        repeat (pause_n) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      got = '{item_kind_o, content_byte_o, verdict_o, was_truncated_o, seq_number_o};
      items_checked++;
      if (got.item_kind == KindEnd) begin
        ends_checked++;
        if (got.was_truncated) cut_ends++;
      end
      if (due_items.size() == 0) begin
        $error("result item with nothing expected: kind %0d byte %0d verdict %0d",
               got.item_kind, got.content_byte, got.verdict);
        mismatches++;
      end else begin
        want = due_items.pop_front();
        check_field("item_kind", 32'(want.item_kind), 32'(got.item_kind));
        check_field("content_byte", 32'(want.content_byte), 32'(got.content_byte));
        check_field("verdict", 32'(want.verdict), 32'(got.verdict));
        check_field("was_truncated", 32'(want.was_truncated), 32'(got.was_truncated));
        check_field("seq_number", 32'(want.seq_number), 32'(got.seq_number));
      end
      if ($urandom_range(0, 29) == 0) sink_busy = !sink_busy;
    end
  end

  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int unsigned target;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    stream_byte_i = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    sender_busy   = 1'b1;
    size_limit    = MaxFrameReset;
    clear_frame_state();
    last_seq      = '0;
    discarding    = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    apply_frame_limit(1'b0, '0);
    foreach (opening_rows[i]) begin
      push_byte(opening_rows[i].data, opening_rows[i].pinned, opening_rows[i].yields,
                opening_rows[i].res);
    end

    // The first phase runs with the reset limit, the rest with written ones.
    for (int p = 0; p <= NumLimits; p++) begin
      if (p != 0) begin
        wait_quiet();
        apply_frame_limit(1'b1, (p == 5) ? 20'($urandom_range(8, 48)) : limit_plan[p-1]);
      end
      target = bytes_sent + PhaseBytes;
      while (bytes_sent < target) begin
        send_frame();
        if ($urandom_range(0, 29) == 0) wait_quiet();
      end
    end
    wait_quiet();

    $display("Sent %0d stream bytes in %0d frames under %0d written size limits.",
             bytes_sent, frames_sent, limits_used);
    $display("Checked %0d result items: %0d frame ends, %0d of them cut at the limit.",
             items_checked, ends_checked, cut_ends);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
